FILE: hdl/tpps_pkg.sv
// shared types, constants and command/status records for the
// trapezoid profile pid speed controller; no dependencies
package tpps_pkg;

    localparam int unsigned TICK_W   = 16;   // phase tick counters, hold interval
    localparam int unsigned STEP_W   = 16;   // accel step, Q8.8
    localparam int unsigned GAIN_W   = 24;   // pid gains, Q12.12
    localparam int unsigned CNT_W    = 32;   // encoder count, speed, targets
    localparam int unsigned DRV_W    = 48;   // Q32.16 loop values
    localparam int unsigned FRAC_W   = 16;   // fraction bits of Q32.16
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned CFG_DW   = 24;
    localparam int unsigned SCALE_W  = 16;   // speed scale, Q8.8

    localparam int unsigned SPEED_SCALE_Q8_DEF = 256;
    localparam int unsigned PERIOD_SHIFT_DEF   = 10;

    typedef enum logic [CFG_AW-1:0] {
        CFG_PROP_GAIN,
        CFG_INTEG_GAIN,
        CFG_DERIV_GAIN,
        CFG_ACCEL_STEP,
        CFG_HOLD_INTERVAL,
        CFG_ACCEL_TICKS,
        CFG_CRUISE_TICKS,
        CFG_DECEL_TICKS
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_ACCEL,
        PH_CRUISE,
        PH_DECEL,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        MUL_HOLD_STEP,
        MUL_TARGET,
        MUL_HI,
        MUL_LO
    } mul_sel_t;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } term_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_DONE,
        OUT_DRIVE
    } out_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RST_CLR,
        ST_PHASE,
        ST_REM_GO,
        ST_REM,
        ST_ERR_A,
        ST_ERR_B,
        ST_MPH,
        ST_MPL,
        ST_MACC,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C,
        ST_PUSH
    } ctrl_state_t;

    typedef struct packed {
        logic      load_in;
        logic      rst_clear;
        logic      phase_upd;
        logic      rem_start;
        logic      latch_upd;
        logic      mul_en;
        mul_sel_t  mul_sel;
        term_t     term;
        logic      err_a;
        logic      err_b;
        logic      hi_take;
        logic      lo_take;
        logic      fin_a;
        logic      fin_b;
        logic      fin_c;
        logic      push;
        out_kind_t push_kind;
    } tpps_cmd_t;

    typedef struct packed {
        logic act;
        logic finished;
        logic rem_done;
        logic out_free;
    } tpps_stat_t;

endpackage

FILE: hdl/tpps_rem.sv
// iterative remainder unit, four restoring steps per cycle, used for the
// tick-count versus hold-interval latch test; depends on tpps_pkg
module tpps_rem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tpps_pkg::TICK_W-1:0] dividend,
    input  logic [tpps_pkg::TICK_W-1:0] divisor,
    output logic                        done,
    output logic                        zero
);
    import tpps_pkg::*;

    localparam int unsigned BITS_PER_CYC = 4;
    localparam int unsigned ITER         = TICK_W / BITS_PER_CYC;
    localparam int unsigned IW           = (ITER > 1) ? $clog2(ITER) : 1;

    logic              busy_reg, done_reg;
    logic [IW-1:0]     cnt_reg;
    logic [TICK_W-1:0] num_reg, rem_reg, div_reg;
    logic [TICK_W-1:0] num_next, rem_next;

    // a zero divisor acts as one
    always_comb
    begin
        logic [TICK_W:0] t;
        logic [TICK_W-1:0] r, n;
        r = rem_reg;
        n = num_reg;
        for (int i = 0; i < BITS_PER_CYC; i++)
        begin
            t = {r, n[TICK_W-1]};
            n = {n[TICK_W-2:0], 1'b0};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            r = t[TICK_W-1:0];
        end
        rem_next = r;
        num_next = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + IW'(1);
            if (cnt_reg == IW'(ITER - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            div_reg <= (divisor == '0) ? TICK_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign zero = (rem_reg == '0);

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("remainder restarted while busy");

endmodule

FILE: hdl/tpps_dp.sv
// datapath: configuration registers, profile and loop state, shared
// 32x24 multiplier, remainder unit and output register; uses tpps_pkg, tpps_rem
module tpps_dp #(
    parameter int unsigned SPEED_SCALE_Q8 = tpps_pkg::SPEED_SCALE_Q8_DEF,
    parameter int unsigned PERIOD_SHIFT   = tpps_pkg::PERIOD_SHIFT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tpps_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [tpps_pkg::CFG_DW-1:0] cfg_wdata,
    input  logic                        in_action,
    input  logic [tpps_pkg::CNT_W-1:0]  in_count,
    input  tpps_pkg::tpps_cmd_t         cmd,
    output tpps_pkg::tpps_stat_t        stat,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [tpps_pkg::DRV_W-1:0]  out_drive,
    output logic                        out_done
);
    import tpps_pkg::*;

    localparam int unsigned EXT_W   = 65;
    localparam int unsigned MA_W    = 32;
    localparam int unsigned MQ_W    = MA_W + GAIN_W;
    localparam int unsigned HALF_W  = DRV_W / 2;
    localparam int unsigned HI_W    = 35;
    localparam int unsigned TOT_W   = 60;
    localparam int unsigned GSH     = 12;
    localparam int unsigned INT_SH  = FRAC_W - PERIOD_SHIFT;
    localparam int unsigned DQ_SH   = FRAC_W + PERIOD_SHIFT;
    localparam logic signed [EXT_W-1:0] MAX48 = 65'sd140737488355327;
    localparam logic signed [EXT_W-1:0] MIN48 = -65'sd140737488355328;
    localparam logic [DRV_W-1:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [DRV_W-1:0] NEG_LIM = 48'h8000_0000_0000;
    localparam logic [DRV_W-1:0] RND     = (DRV_W'(1) << PERIOD_SHIFT) - DRV_W'(1);

    function automatic logic signed [DRV_W-1:0] sat48(input logic signed [EXT_W-1:0] x);
        logic signed [DRV_W-1:0] r;
        if (x > MAX48)
            r = MAX48[DRV_W-1:0];
        else if (x < MIN48)
            r = MIN48[DRV_W-1:0];
        else
            r = x[DRV_W-1:0];
        return r;
    endfunction

    function automatic logic signed [CNT_W-1:0] sat32(input logic signed [CNT_W:0] x);
        logic signed [CNT_W-1:0] r;
        if (x > 33'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (x < -33'sd2147483648)
            r = 32'h8000_0000;
        else
            r = x[CNT_W-1:0];
        return r;
    endfunction

    // configuration
    logic [GAIN_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [STEP_W-1:0] accel_step_reg;
    logic [TICK_W-1:0] hold_interval_reg, accel_ticks_reg, cruise_ticks_reg, decel_ticks_reg;

    // profile and loop state
    phase_t                  phase_reg;
    logic [TICK_W-1:0]       ticks_reg;
    logic [CNT_W-1:0]        last_count_reg;
    logic signed [CNT_W-1:0] pending_reg, latched_reg, last_err_reg;
    logic signed [DRV_W-1:0] integ_reg, last_pid_reg, last_vel_reg, drive_reg;
    logic                    act_reg;

    // working registers
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [CNT_W-1:0] spd_reg, err_reg;
    logic signed [DRV_W-1:0] dq_reg, op_reg, dv_reg;
    logic [MQ_W-1:0]         mul_q_reg;
    logic                    tgt_neg_reg, hi_sat_reg;
    logic [HI_W-1:0]         hi_reg;
    logic signed [DRV_W+1:0] op_acc_reg;

    logic                    out_valid_reg, out_done_reg;
    logic [DRV_W-1:0]        out_drive_reg;

    logic                    rem_done, rem_zero;

    // combinational
    logic [TICK_W-1:0]       len_c;
    phase_t                  phase_adv_c;
    logic signed [CNT_W-1:0] latch_src_c, tgt_c, err_c, pending_c;
    logic [CNT_W-1:0]        src_mag_c, tgt_mag_c;
    logic signed [DRV_W-1:0] integ_c, dq_c, op_c, dv_c, ov_c, drive_c;
    logic signed [DRV_W-1:0] x_c;
    logic                    x_neg_c;
    logic [DRV_W-1:0]        x_mag_c, t_c, lim_c, mag_c;
    logic [GAIN_W-1:0]       gain_c;
    logic [TOT_W-1:0]        total_c;
    logic signed [DRV_W:0]   term_c, shr_c;
    logic [MA_W-1:0]         mul_a_c;
    logic [GAIN_W-1:0]       mul_b_c;

    tpps_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.rem_start),
        .dividend (ticks_reg),
        .divisor  (hold_interval_reg),
        .done     (rem_done),
        .zero     (rem_zero)
    );

    always_comb
    begin
        unique case (phase_reg)
            PH_ACCEL:  len_c = accel_ticks_reg;
            PH_CRUISE: len_c = cruise_ticks_reg;
            default:   len_c = decel_ticks_reg;
        endcase
        unique case (phase_reg)
            PH_ACCEL:  phase_adv_c = (cruise_ticks_reg == '0) ? PH_DECEL : PH_CRUISE;
            PH_CRUISE: phase_adv_c = PH_DECEL;
            PH_DECEL:  phase_adv_c = PH_DONE;
            PH_DONE:   phase_adv_c = PH_DONE;
        endcase

        // target latch source and its magnitude for the scale multiply
        latch_src_c = rem_zero ? pending_reg : latched_reg;
        src_mag_c   = latch_src_c[CNT_W-1] ? CNT_W'(-latch_src_c) : CNT_W'(latch_src_c);

        tgt_mag_c = mul_q_reg[FRAC_W +: CNT_W];
        tgt_c     = tgt_neg_reg ? CNT_W'(-tgt_mag_c) : CNT_W'(tgt_mag_c);
        err_c     = sat32((CNT_W+1)'(tgt_c) - (CNT_W+1)'(spd_reg));

        integ_c = sat48(EXT_W'(integ_reg) + (EXT_W'(err_reg) <<< INT_SH));
        dq_c    = sat48((EXT_W'(err_reg) - EXT_W'(last_err_reg)) <<< DQ_SH);

        // pid term operand and gain
        unique case (cmd.term)
            TERM_P:
            begin
                x_c    = {err_reg, {FRAC_W{1'b0}}};
                gain_c = prop_gain_reg;
            end
            TERM_I:
            begin
                x_c    = integ_reg;
                gain_c = integ_gain_reg;
            end
            TERM_D:
            begin
                x_c    = dq_reg;
                gain_c = deriv_gain_reg;
            end
            default:
            begin
                x_c    = '0;
                gain_c = '0;
            end
        endcase
        x_neg_c = x_c[DRV_W-1];
        x_mag_c = x_neg_c ? DRV_W'(-x_c) : DRV_W'(x_c);

        unique case (cmd.mul_sel)
            MUL_HOLD_STEP:
            begin
                mul_a_c = MA_W'(hold_interval_reg);
                mul_b_c = GAIN_W'(accel_step_reg);
            end
            MUL_TARGET:
            begin
                mul_a_c = src_mag_c;
                mul_b_c = GAIN_W'(SCALE_W'(SPEED_SCALE_Q8));
            end
            MUL_HI:
            begin
                mul_a_c = MA_W'(x_mag_c[DRV_W-1:HALF_W]);
                mul_b_c = gain_c;
            end
            MUL_LO:
            begin
                mul_a_c = MA_W'(x_mag_c[HALF_W-1:0]);
                mul_b_c = gain_c;
            end
        endcase

        // recombine the two partial products, drop 12 gain fraction bits
        total_c = TOT_W'({hi_reg, {HALF_W{1'b0}}}) + TOT_W'(mul_q_reg[DRV_W-1:0]);
        t_c     = total_c[GSH +: DRV_W];
        lim_c   = x_neg_c ? NEG_LIM : POS_LIM;
        mag_c   = (hi_sat_reg || (t_c > lim_c)) ? lim_c : t_c;
        term_c  = x_neg_c ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

        op_c = sat48(EXT_W'(op_acc_reg));
        dv_c = sat48((EXT_W'(op_c) - EXT_W'(last_pid_reg)) <<< PERIOD_SHIFT);
        ov_c = sat48(EXT_W'(dv_reg) + EXT_W'(last_vel_reg));

        // shift toward zero
        shr_c   = ($signed({last_vel_reg[DRV_W-1], last_vel_reg})
                   + $signed({1'b0, (last_vel_reg[DRV_W-1] ? RND : '0)})) >>> PERIOD_SHIFT;
        drive_c = sat48(EXT_W'(drive_reg) + EXT_W'(shr_c));

        unique case (phase_reg)
            PH_ACCEL: pending_c = sat32((CNT_W+1)'(pending_reg)
                                        + $signed((CNT_W+1)'(accel_step_reg)));
            PH_DECEL: pending_c = sat32((CNT_W+1)'(pending_reg)
                                        - $signed((CNT_W+1)'(accel_step_reg)));
            default:  pending_c = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            accel_step_reg    <= '0;
            hold_interval_reg <= TICK_W'(1);
            accel_ticks_reg   <= '0;
            cruise_ticks_reg  <= '0;
            decel_ticks_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_PROP_GAIN:     prop_gain_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_GAIN:    integ_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_DERIV_GAIN:    deriv_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_ACCEL_STEP:    accel_step_reg    <= cfg_wdata[STEP_W-1:0];
                CFG_HOLD_INTERVAL: hold_interval_reg <= cfg_wdata[TICK_W-1:0];
                CFG_ACCEL_TICKS:   accel_ticks_reg   <= cfg_wdata[TICK_W-1:0];
                CFG_CRUISE_TICKS:  cruise_ticks_reg  <= cfg_wdata[TICK_W-1:0];
                CFG_DECEL_TICKS:   decel_ticks_reg   <= cfg_wdata[TICK_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg        <= 1'b0;
            phase_reg      <= PH_ACCEL;
            ticks_reg      <= '0;
            last_count_reg <= '0;
            pending_reg    <= '0;
            latched_reg    <= '0;
            last_err_reg   <= '0;
            integ_reg      <= '0;
            last_pid_reg   <= '0;
            last_vel_reg   <= '0;
            drive_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                act_reg <= in_action;
            end
            if (cmd.rst_clear)
            begin
                phase_reg      <= PH_ACCEL;
                ticks_reg      <= '0;
                last_count_reg <= '0;
                pending_reg    <= mul_q_reg[CNT_W-1] ? 32'h7FFF_FFFF : mul_q_reg[CNT_W-1:0];
                latched_reg    <= '0;
                last_err_reg   <= '0;
                integ_reg      <= '0;
                last_pid_reg   <= '0;
                last_vel_reg   <= '0;
                drive_reg      <= '0;
            end
            if (cmd.phase_upd)
            begin
                if (ticks_reg == len_c)
                begin
                    ticks_reg <= '0;
                    phase_reg <= phase_adv_c;
                end
                last_count_reg <= cnt_reg;
            end
            if (cmd.latch_upd && rem_zero)
            begin
                latched_reg <= pending_reg;
            end
            if (cmd.err_b)
            begin
                integ_reg    <= integ_c;
                last_err_reg <= err_reg;
            end
            if (cmd.fin_b)
            begin
                last_pid_reg <= op_reg;
                last_vel_reg <= ov_c;
            end
            if (cmd.fin_c)
            begin
                drive_reg   <= drive_c;
                pending_reg <= pending_c;
                ticks_reg   <= ticks_reg + TICK_W'(1);
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cnt_reg <= in_count;
        end
        if (cmd.phase_upd)
        begin
            spd_reg <= cnt_reg - last_count_reg;
        end
        if (cmd.mul_en)
        begin
            mul_q_reg <= MQ_W'(mul_a_c) * MQ_W'(mul_b_c);
        end
        if (cmd.latch_upd)
        begin
            tgt_neg_reg <= latch_src_c[CNT_W-1];
        end
        if (cmd.err_a)
        begin
            err_reg <= err_c;
        end
        if (cmd.err_b)
        begin
            dq_reg     <= dq_c;
            op_acc_reg <= '0;
        end
        if (cmd.hi_take)
        begin
            hi_sat_reg <= |mul_q_reg[MQ_W-1:HI_W];
            hi_reg     <= mul_q_reg[HI_W-1:0];
        end
        if (cmd.lo_take)
        begin
            op_acc_reg <= op_acc_reg + (DRV_W+2)'(term_c);
        end
        if (cmd.fin_a)
        begin
            op_reg <= op_c;
            dv_reg <= dv_c;
        end
        if (cmd.push)
        begin
            unique case (cmd.push_kind)
                OUT_DONE:
                begin
                    out_drive_reg <= '0;
                    out_done_reg  <= 1'b1;
                end
                OUT_DRIVE:
                begin
                    out_drive_reg <= drive_reg;
                    out_done_reg  <= 1'b0;
                end
                default:
                begin
                    out_drive_reg <= '0;
                    out_done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign stat.act      = act_reg;
    assign stat.finished = (phase_reg == PH_DONE);
    assign stat.rem_done = rem_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_drive = out_drive_reg;
    assign out_done  = out_done_reg;

    a_tick_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.phase_upd |-> phase_reg != PH_DONE)
        else $error("control tick run on a finished profile");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && cmd.push_kind == OUT_DONE) |-> phase_reg == PH_DONE)
        else $error("done result while profile still running");

endmodule

FILE: hdl/tpps_ctrl.sv
// controller state machine: sequences phase update, latch test, error,
// three pid terms on the shared multiplier and the drive update; uses tpps_pkg
module tpps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output tpps_pkg::tpps_cmd_t  cmd,
    input  tpps_pkg::tpps_stat_t stat
);
    import tpps_pkg::*;

    ctrl_state_t state_reg, state_next;
    term_t       k_reg, k_next;
    out_kind_t   kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= TERM_P;
            kind_reg  <= OUT_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = MUL_HI;
        cmd.term      = k_reg;
        cmd.push_kind = kind_reg;
        in_ready      = 1'b0;
        state_next    = state_reg;
        k_next        = k_reg;
        kind_next     = kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (stat.act)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_HOLD_STEP;
                    state_next  = ST_RST_CLR;
                end
                else if (stat.finished)
                begin
                    kind_next  = OUT_DONE;
                    state_next = ST_PUSH;
                end
                else
                begin
                    state_next = ST_PHASE;
                end
            end
            ST_RST_CLR:
            begin
                cmd.rst_clear = 1'b1;
                kind_next     = OUT_ZERO;
                state_next    = ST_PUSH;
            end
            ST_PHASE:
            begin
                cmd.phase_upd = 1'b1;
                state_next    = ST_REM_GO;
            end
            ST_REM_GO:
            begin
                cmd.rem_start = 1'b1;
                state_next    = ST_REM;
            end
            ST_REM:
            begin
                if (stat.rem_done)
                begin
                    cmd.latch_upd = 1'b1;
                    cmd.mul_en    = 1'b1;
                    cmd.mul_sel   = MUL_TARGET;
                    state_next    = ST_ERR_A;
                end
            end
            ST_ERR_A:
            begin
                cmd.err_a  = 1'b1;
                state_next = ST_ERR_B;
            end
            ST_ERR_B:
            begin
                cmd.err_b  = 1'b1;
                k_next     = TERM_P;
                state_next = ST_MPH;
            end
            ST_MPH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HI;
                state_next  = ST_MPL;
            end
            ST_MPL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LO;
                cmd.hi_take = 1'b1;
                state_next  = ST_MACC;
            end
            ST_MACC:
            begin
                cmd.lo_take = 1'b1;
                priority if (k_reg == TERM_P)
                begin
                    k_next     = TERM_I;
                    state_next = ST_MPH;
                end
                else if (k_reg == TERM_I)
                begin
                    k_next     = TERM_D;
                    state_next = ST_MPH;
                end
                else
                begin
                    state_next = ST_FIN_A;
                end
            end
            ST_FIN_A:
            begin
                cmd.fin_a  = 1'b1;
                state_next = ST_FIN_B;
            end
            ST_FIN_B:
            begin
                cmd.fin_b  = 1'b1;
                state_next = ST_FIN_C;
            end
            ST_FIN_C:
            begin
                cmd.fin_c  = 1'b1;
                kind_next  = OUT_DRIVE;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_hi_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hi_take |-> $past(cmd.mul_en && cmd.mul_sel == MUL_HI))
        else $error("high partial product taken without issue");

    a_lo_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lo_take |-> $past(cmd.mul_en && cmd.mul_sel == MUL_LO))
        else $error("low partial product taken without issue");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> stat.out_free)
        else $error("result pushed over an untaken result");

endmodule

FILE: hdl/trapezoid_profile_pid_speed.sv
// top level of the trapezoid profile pid speed controller
// depends on tpps_pkg, tpps_ctrl, tpps_dp (which holds tpps_rem)
//
// One request on the input stream is one control tick: tdata carries the
// cumulative encoder count, tuser the action (0 = control tick, 1 = reset of
// profile and loop state). Every request gives exactly one result: tdata is the
// integrated drive in signed Q32.16, tuser is profile_done. On a control tick,
// from acceptance until its result is registered, an iterative remainder unit
// decides whether the pending target is latched, then the three pid terms each
// take two passes through the single shared 32x24 multiplier, and the velocity
// stage and drive integration take three more steps. The next request is
// accepted as soon as the result sits in the output register, even if the
// downstream side has not taken it yet. Configuration is to be written by the
// user through cfg_we/cfg_addr/cfg_wdata between requests, which the block
// does not enforce, one register per cycle, no read-back; it takes effect on
// the next request.
module trapezoid_profile_pid_speed #(
    parameter int unsigned SPEED_SCALE_Q8 = tpps_pkg::SPEED_SCALE_Q8_DEF,  // pulses per unit, Q8.8
    parameter int unsigned PERIOD_SHIFT   = tpps_pkg::PERIOD_SHIFT_DEF     // tick period 2^-n
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tpps_pkg::CNT_W-1:0]  s_tdata,   // [31:0] encoder_count
    input  logic                        s_tuser,   // [0] action
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tpps_pkg::DRV_W-1:0]  m_tdata,   // [47:0] drive
    output logic                        m_tuser,   // [0] profile_done
    // configuration writes
    input  logic                        cfg_we,
    input  logic [tpps_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [tpps_pkg::CFG_DW-1:0] cfg_wdata
);
    import tpps_pkg::*;

    tpps_cmd_t  cmd;
    tpps_stat_t stat;

    // sequencer: one request at a time, waits for the output slot at the end
    tpps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // arithmetic, state and output register
    tpps_dp #(
        .SPEED_SCALE_Q8 (SPEED_SCALE_Q8),
        .PERIOD_SHIFT   (PERIOD_SHIFT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_action (s_tuser),
        .in_count  (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_drive (m_tdata),
        .out_done  (m_tuser)
    );

endmodule

FILE: sim/trapezoid_profile_pid_speed_tb.sv
// self-checking testbench for the trapezoid profile pid speed controller:
// directed table then random profiles, checked against an in-bench speed loop
// depends on tpps_pkg and trapezoid_profile_pid_speed from hdl
module trapezoid_profile_pid_speed_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpps_pkg::*;

    typedef longint unsigned u64_t;

    // fixed-point limits of the loop values
    localparam longint LIM48  = 64'sh7FFF_FFFF_FFFF;
    localparam longint LIM32  = 64'sh7FFF_FFFF;
    localparam u64_t   TWO47  = 64'h8000_0000_0000;
    localparam longint SCALE  = longint'(SPEED_SCALE_Q8_DEF);
    localparam int     PSHIFT = int'(PERIOD_SHIFT_DEF);

    // run control
    localparam int          RAND_ITEMS    = 550;
    localparam int          SETTLE_CYCLES = 32;      // one control tick plus margin
    localparam int          HOLD_AT       = 150;     // results seen before the long hold-off
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic [DRV_W-1:0] drive;
        logic             done;
    } drive_result_t;

    typedef enum logic {
        ROW_CFG,
        ROW_REQ
    } row_kind_t;

    // one line of the directed table: a register write or a request
    typedef struct packed {
        row_kind_t        kind;
        cfg_idx_t         reg_sel;
        logic [CFG_DW-1:0] value;
        logic             act;
        logic [CNT_W-1:0] count;
        logic             known;     // result typed in below, else computed
        drive_result_t    typed;
    } stim_row_t;

    logic clk;
    logic rst_n = 1'b0;

    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [CNT_W-1:0]  s_tdata   = '0;    // [31:0] encoder_count
    logic              s_tuser   = 1'b0;  // [0] action
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DRV_W-1:0]  m_tdata;           // [47:0] drive
    logic              m_tuser;           // [0] profile_done
    logic              cfg_we    = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;

    trapezoid_profile_pid_speed i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // bench copy of the register file and the loop state
    // ------------------------------------------------------------------
    u64_t        kp, ki, kd;
    int unsigned step, hold_iv, len_accel, len_cruise, len_decel;

    phase_t      prof_phase;
    int unsigned phase_ticks;
    logic [31:0] last_cnt;
    longint      pending_target, latched_target, last_err;
    longint      err_integral, last_pid, last_vel, drive_accum;

    drive_result_t drives_in_flight [$];  // drives owed by the block, oldest first
    int            mismatches   = 0;
    int            results_seen = 0;
    bit            steady       = 1'b0;  // no idling on either side
    bit            cfg_pause    = 1'b0;  // sender drained and waiting to write registers
    int unsigned   cycle_count  = 0;

    function automatic longint sat(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim - 1)
            return -lim - 1;
        return x;
    endfunction

    function automatic u64_t mag(input longint x);
        return (x < 0) ? $unsigned(-x) : $unsigned(x);
    endfunction

    // magnitude and sign back to a saturated 48-bit value
    function automatic longint from_mag(input u64_t m, input bit neg);
        if (neg)
        begin
            if (m > TWO47)
                m = TWO47;
            return -longint'(m);
        end
        if (m > TWO47 - 1)
            m = TWO47 - 1;
        return longint'(m);
    endfunction

    // right shift rounding toward zero
    function automatic longint shr_trunc(input longint x, input int s);
        return from_mag(mag(x) >> s, x < 0);
    endfunction

    function automatic longint shl_sat(input longint x, input int s);
        u64_t m;
        m = mag(x);
        if (m > (TWO47 >> s))
            m = TWO47 + 1;
        else
            m = m << s;
        return from_mag(m, x < 0);
    endfunction

    // Q32.16 times unsigned Q12.12 gain, split in high and low 24-bit halves
    function automatic longint gain_mul(input longint x, input u64_t g);
        u64_t m, a, t;
        m = mag(x);
        if (m > TWO47)
            m = TWO47;
        a = (m >> 24) * g;
        if (a >= (64'd1 << 35))
            t = TWO47 + 1;
        else
            t = ((a << 24) + (m & 64'hFF_FFFF) * g) >> 12;
        return from_mag(t, x < 0);
    endfunction

    function automatic void clear_loop_state();
        prof_phase     = PH_ACCEL;
        phase_ticks    = 0;
        last_cnt       = '0;
        pending_target = sat(longint'(hold_iv) * longint'(step), LIM32);
        latched_target = 0;
        last_err       = 0;
        err_integral   = 0;
        last_pid       = 0;
        last_vel       = 0;
        drive_accum    = 0;
    endfunction

    // one control tick (or reset action) through the profile and the loop
    function automatic void step_speed_loop(input logic act, input logic [31:0] cnt,
                                            output drive_result_t res);
        longint      spd, target, err, dq, op, dv, ov;
        int unsigned len, hold;
        logic [31:0] diff;
        res.drive = '0;
        res.done  = 1'b0;
        if (act)
        begin
            clear_loop_state();
            return;
        end
        if (prof_phase == PH_DONE)
        begin
            res.done = 1'b1;
            return;
        end

        // phase advance, empty cruise skipped
        len = (prof_phase == PH_ACCEL) ? len_accel :
              (prof_phase == PH_CRUISE) ? len_cruise : len_decel;
        if (phase_ticks == len)
        begin
            phase_ticks = 0;
            prof_phase  = prof_phase.next();
            if (prof_phase == PH_CRUISE && len_cruise == 0)
                prof_phase = PH_DECEL;
        end

        // speed is the wrapped count difference
        diff     = cnt - last_cnt;
        spd      = longint'($signed(diff));
        last_cnt = cnt;

        hold = (hold_iv == 0) ? 1 : hold_iv;
        if (phase_ticks % hold == 0)
            latched_target = pending_target;

        target       = sat(shr_trunc(latched_target * SCALE, 16), LIM32);
        err          = sat(target - spd, LIM32);
        err_integral = sat(err_integral + shr_trunc(err * 65536, PSHIFT), LIM48);
        dq           = shl_sat(err - last_err, 16 + PSHIFT);
        last_err     = err;

        op = sat(gain_mul(err * 65536, kp) + gain_mul(err_integral, ki)
                 + gain_mul(dq, kd), LIM48);

        // velocity form, then integrate into the drive
        dv          = shl_sat(op - last_pid, PSHIFT);
        ov          = sat(dv + last_vel, LIM48);
        last_pid    = op;
        last_vel    = ov;
        drive_accum = sat(drive_accum + shr_trunc(ov, PSHIFT), LIM48);

        if (prof_phase == PH_ACCEL)
            pending_target = sat(pending_target + longint'(step), LIM32);
        else if (prof_phase == PH_DECEL)
            pending_target = sat(pending_target - longint'(step), LIM32);

        phase_ticks = (phase_ticks + 1) & 32'hFFFF;
        res.drive   = drive_accum[DRV_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly short gaps, a few long ones, none while steady
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic stim_row_t cfg_row(input cfg_idx_t r, input logic [CFG_DW-1:0] v);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_sel = r;
        row.value   = v;
        return row;
    endfunction

    function automatic stim_row_t tick_row(input logic act, input logic [CNT_W-1:0] cnt);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_REQ;
        row.act   = act;
        row.count = cnt;
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic act, input logic [CNT_W-1:0] cnt,
                                            input logic [DRV_W-1:0] drv, input logic done);
        stim_row_t row;
        row             = tick_row(act, cnt);
        row.known       = 1'b1;
        row.typed.drive = drv;
        row.typed.done  = done;
        return row;
    endfunction

    // one register write per clock; caller lowers cfg_we after the last one
    task automatic write_reg(input cfg_idx_t r, input logic [CFG_DW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge clk);
        case (r)
            CFG_PROP_GAIN:     kp         = u64_t'(v);
            CFG_INTEG_GAIN:    ki         = u64_t'(v);
            CFG_DERIV_GAIN:    kd         = u64_t'(v);
            CFG_ACCEL_STEP:    step       = v[15:0];
            CFG_HOLD_INTERVAL: hold_iv    = v[15:0];
            CFG_ACCEL_TICKS:   len_accel  = v[15:0];
            CFG_CRUISE_TICKS:  len_cruise = v[15:0];
            CFG_DECEL_TICKS:   len_decel  = v[15:0];
            default: ;
        endcase
    endtask

    // offer one request, hold it until taken, then book the drive it owes
    task automatic send_request(input logic act, input logic [CNT_W-1:0] cnt,
                                input logic known, input drive_result_t typed);
        int            gap;
        drive_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= cnt;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        step_speed_loop(act, cnt, res);
        drives_in_flight.push_back(known ? typed : res);
    endtask

    // wait until every owed drive came back and the block is idle
    task automatic drain_results();
        s_tvalid  <= 1'b0;
        cfg_pause  = 1'b1;
        while (drives_in_flight.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_pause = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // stimulus: directed table, then random profiles
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t     stim_table [$];
        drive_result_t no_result;
        bit            in_cfg;
        bit            first_setting;
        int            rand_items;
        int            n_items;
        int            roll;
        int            speed;
        logic [31:0]   pos;
        logic [31:0]   cnt;
        logic [23:0]   val;
        cfg_idx_t      reg_sel;

        // power-on register values and loop state
        kp = 0; ki = 0; kd = 0; step = 0;
        hold_iv = 1; len_accel = 0; len_cruise = 0; len_decel = 0;
        clear_loop_state();
        no_result = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stim_table = '{
            // reset values: zero gains keep the drive at 0, counts at the extremes
            known_row(1'b0, 32'h0000_0000, 48'h0, 1'b0),
            known_row(1'b0, 32'h7FFF_FFFF, 48'h0, 1'b0),
            known_row(1'b0, 32'h8000_0000, 48'h0, 1'b0),   // count rollover
            known_row(1'b1, 32'hFFFF_FFFF, 48'h0, 1'b0),   // reset action
            // max proportional gain and step, pending target saturates
            cfg_row(CFG_PROP_GAIN,     24'hFF_FFFF),
            cfg_row(CFG_INTEG_GAIN,    24'h00_0000),
            cfg_row(CFG_DERIV_GAIN,    24'h00_0000),
            cfg_row(CFG_ACCEL_STEP,    24'h00_FFFF),
            cfg_row(CFG_HOLD_INTERVAL, 24'h00_FFFF),
            cfg_row(CFG_ACCEL_TICKS,   24'h00_0002),
            cfg_row(CFG_CRUISE_TICKS,  24'h00_0001),
            cfg_row(CFG_DECEL_TICKS,   24'h00_0001),
            known_row(1'b1, 32'h0000_0000, 48'h0, 1'b0),
            tick_row(1'b0, 32'h0000_0000),
            tick_row(1'b0, 32'h8000_0000),
            tick_row(1'b0, 32'h7FFF_FFFF),
            tick_row(1'b0, 32'h0000_0000),
            tick_row(1'b0, 32'h1234_5678),                 // finishing tick
            known_row(1'b0, 32'hFFFF_FFFF, 48'h0, 1'b1),   // profile finished
            // moderate gains, zero hold interval, empty cruise skipped
            cfg_row(CFG_PROP_GAIN,     24'h00_1000),
            cfg_row(CFG_INTEG_GAIN,    24'h00_0800),
            cfg_row(CFG_DERIV_GAIN,    24'h00_0100),
            cfg_row(CFG_ACCEL_STEP,    24'h00_0100),
            cfg_row(CFG_HOLD_INTERVAL, 24'h00_0000),
            cfg_row(CFG_ACCEL_TICKS,   24'h00_0003),
            cfg_row(CFG_CRUISE_TICKS,  24'h00_0000),
            cfg_row(CFG_DECEL_TICKS,   24'h00_0003),
            known_row(1'b1, 32'h0000_0000, 48'h0, 1'b0),
            tick_row(1'b0, 32'h0000_0010),
            tick_row(1'b0, 32'h0000_0030),
            tick_row(1'b0, 32'h0000_0060),
            tick_row(1'b0, 32'h0000_0090),
            tick_row(1'b0, 32'h0000_00B0),
            tick_row(1'b0, 32'h0000_00C0),
            tick_row(1'b0, 32'h0000_00C8),
            known_row(1'b0, 32'h0000_00D0, 48'h0, 1'b1),
            // all gains at max, then accel length lowered mid-phase
            cfg_row(CFG_PROP_GAIN,     24'hFF_FFFF),
            cfg_row(CFG_INTEG_GAIN,    24'hFF_FFFF),
            cfg_row(CFG_DERIV_GAIN,    24'hFF_FFFF),
            cfg_row(CFG_ACCEL_STEP,    24'h00_8000),
            cfg_row(CFG_HOLD_INTERVAL, 24'h00_0002),
            cfg_row(CFG_ACCEL_TICKS,   24'h00_0004),
            cfg_row(CFG_CRUISE_TICKS,  24'h00_0002),
            cfg_row(CFG_DECEL_TICKS,   24'h00_0000),
            known_row(1'b1, 32'h5555_5555, 48'h0, 1'b0),
            tick_row(1'b0, 32'hAAAA_AAAA),
            tick_row(1'b0, 32'h0000_0000),
            tick_row(1'b0, 32'h7FFF_FFFF),
            cfg_row(CFG_ACCEL_TICKS,   24'h00_0001),
            tick_row(1'b0, 32'h8000_0001)
        };

        // walk the table; register writes only once the block is idle
        in_cfg = 1'b0;
        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_CFG)
            begin
                if (!in_cfg)
                    drain_results();
                in_cfg = 1'b1;
                write_reg(stim_table[i].reg_sel, stim_table[i].value);
            end
            else
            begin
                if (in_cfg)
                    cfg_we <= 1'b0;
                in_cfg = 1'b0;
                send_request(stim_table[i].act, stim_table[i].count,
                             stim_table[i].known, stim_table[i].typed);
            end
        end

        // random profiles: new settings, usually a reset action, then a run of
        // encoder counts that follow a plausible speed with some noise mixed in
        rand_items    = 0;
        first_setting = 1'b1;
        while (rand_items < RAND_ITEMS)
        begin
            drain_results();
            steady = ($urandom_range(0, 99) < 20);

            for (int r = 0; r < 8; r++)
            begin
                if (first_setting || $urandom_range(0, 9) < 6)
                begin
                    reg_sel = cfg_idx_t'(r);
                    roll    = $urandom_range(0, 99);
                    case (reg_sel)
                        CFG_PROP_GAIN, CFG_INTEG_GAIN, CFG_DERIV_GAIN:
                            val = (roll < 10) ? 24'h0 :
                                  (roll < 20) ? 24'hFF_FFFF :
                                  (roll < 35) ? 24'($urandom()) :
                                  24'($urandom_range(0, 24'h3000));
                        CFG_ACCEL_STEP:
                            val = (roll < 8)  ? 24'h0 :
                                  (roll < 16) ? 24'h00_FFFF :
                                  (roll < 30) ? 24'($urandom_range(0, 16'hFFFF)) :
                                  24'($urandom_range(1, 16'h0300));
                        CFG_HOLD_INTERVAL:
                            val = (roll < 5)  ? 24'h0 :
                                  (roll < 12) ? 24'h00_FFFF :
                                  (roll < 20) ? 24'($urandom_range(0, 16'hFFFF)) :
                                  24'($urandom_range(1, 4));
                        default:
                            val = (roll < 10) ? 24'h0 :
                                  (roll < 15) ? 24'h00_FFFF :
                                  (roll < 20) ? 24'($urandom_range(0, 16'hFFFF)) :
                                  24'($urandom_range(1, 10));
                    endcase
                    write_reg(reg_sel, val);
                end
            end
            cfg_we <= 1'b0;
            first_setting = 1'b0;

            // without a reset action the new lengths act on a running profile
            if ($urandom_range(0, 99) < 85)
            begin
                send_request(1'b1, $urandom(), 1'b0, no_result);
                rand_items++;
            end

            pos   = $urandom();
            speed = ($urandom_range(0, 99) < 8) ? int'($urandom())
                                                : int'($urandom_range(0, 2000)) - 1000;
            n_items = $urandom_range(8, 40);
            for (int k = 0; k < n_items; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                begin
                    // broken run: reset action in the middle
                    send_request(1'b1, $urandom(), 1'b0, no_result);
                end
                else
                begin
                    if (roll < 14)
                        cnt = $urandom();
                    else
                    begin
                        speed = speed + int'($urandom_range(0, 64)) - 32;
                        pos   = pos + speed;
                        cnt   = pos;
                    end
                    send_request(1'b0, cnt, 1'b0, no_result);
                end
                rand_items++;
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("trapezoid_profile_pid_speed_tb: PASS");
        else
            $display("trapezoid_profile_pid_speed_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stalls, one long hold-off, field-by-field check
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int            stall;
        bit            held_off;
        drive_result_t want;
        held_off = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            // long hold-off while the sender keeps offering, so the block
            // fills its output register and stops taking requests
            if (!held_off && results_seen >= HOLD_AT && !cfg_pause)
            begin
                held_off = 1'b1;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1)
                @(posedge clk);

            results_seen++;
            if (drives_in_flight.size() == 0)
            begin
                $display("%0t: result with none owed, drive %h done %b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = drives_in_flight.pop_front();
                if (m_tdata !== want.drive)
                begin
                    $display("%0t: drive mismatch, expected %h actual %h",
                             $time, want.drive, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.done)
                begin
                    $display("%0t: profile_done mismatch, expected %b actual %b",
                             $time, want.done, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // cycle limit for a hung handshake
    initial
    begin : watchdog
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("trapezoid_profile_pid_speed_tb: FAIL");
        $finish;
    end

endmodule
